// ----- design/sbsp_pkg.sv -----
// ----------------------------------------------------------------------------
// sbsp_pkg
// shared constants for the servo bus status parser
// ----------------------------------------------------------------------------
package sbsp_pkg;

  // default depth of the parameter store
  localparam int MAX_PARAMS_DEF = 16;

  // frame header byte
  localparam logic [7:0] HDR_BYTE = 8'hFF;

  // timeout register reset value
  localparam logic [15:0] TIMEOUT_RESET = 16'd3;

  // input item kinds carried in in_tuser
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // result outcome codes carried in out_tuser[0]
  localparam logic OUTCOME_FRAME   = 1'b0;
  localparam logic OUTCOME_TIMEOUT = 1'b1;

endpackage

// ----- design/sbsp_param_mem.sv -----
// ----------------------------------------------------------------------------
// sbsp_param_mem
// parameter byte store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sbsp_param_mem #(
  parameter int DEPTH = sbsp_pkg::MAX_PARAMS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/servo_bus_status_parser.sv -----
// ----------------------------------------------------------------------------
// servo_bus_status_parser
// hunts received servo bus bytes for the status frame of one target id
// ----------------------------------------------------------------------------
// A start transaction arms the parser with a target id and a wanted
// parameter count; byte transactions are then taken one per cycle and run
// through the header hunt, and tick transactions count toward the timeout in
// cfg_data. Each input transaction is taken whenever the result register is
// free or being emptied in the same cycle. When a frame is accepted its
// wanted parameter bytes are read back from the parameter store one at a
// time through its single registered read port, and input is held off until
// the last byte is loaded into the result register. A timeout or a frame
// with no wanted bytes gives one result at once.
// ----------------------------------------------------------------------------
module servo_bus_status_parser #(
  parameter int MAX_PARAMS = sbsp_pkg::MAX_PARAMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // target_id[7:0], want_count[12:8], rx_byte[20:13]
  input  logic [1:0]  in_tuser,   // kind[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // param_byte[7:0], param_index[11:8]
  output logic [1:0]  out_tuser,  // outcome[0], has_data[1]
  output logic        out_tlast,
  // timeout register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
  localparam int CW = 8;

  // drain sequencer codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  // hunt phase codes
  localparam logic [2:0] HP_FF1  = 3'd0;
  localparam logic [2:0] HP_FF2  = 3'd1;
  localparam logic [2:0] HP_ID   = 3'd2;
  localparam logic [2:0] HP_LEN  = 3'd3;
  localparam logic [2:0] HP_BODY = 3'd4;

  // input fields
  logic [1:0] kind;
  logic [7:0] target_id;
  logic [4:0] want_count;
  logic [7:0] rx_byte;

  assign kind       = in_tuser;
  assign target_id  = in_tdata[7:0];
  assign want_count = in_tdata[12:8];
  assign rx_byte    = in_tdata[20:13];

  logic [1:0]  state_r, state_nxt;
  logic        active_r, active_nxt;
  logic [2:0]  hunt_r, hunt_nxt;
  logic [7:0]  awaited_r, awaited_nxt;
  logic [4:0]  wanted_r, wanted_nxt;
  logic [7:0]  frame_id_r, frame_id_nxt;
  logic [7:0]  frame_len_r, frame_len_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [7:0]  body_r, body_nxt;
  logic [15:0] tick_r, tick_nxt;
  logic [15:0] timeout_r;
  logic [4:0]  k_r, k_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        outcome_r, outcome_nxt;
  logic        has_data_r, has_data_nxt;
  logic [7:0]  pbyte_r, pbyte_nxt;
  logic [3:0]  pidx_r, pidx_nxt;
  logic        last_r, last_nxt;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  logic        out_free;
  logic        in_acc;
  logic [16:0] tick_inc;
  logic [7:0]  body_m1;
  logic        frame_ok;

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_RUN) && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign tick_inc  = {1'b0, tick_r} + 17'd1;
  assign body_m1   = body_r - 8'd1;
  assign frame_ok  = (frame_id_r == awaited_r) && (~sum_r == rx_byte) &&
                     (frame_len_r >= 8'd2) &&
                     ((frame_len_r - 8'd2) >= {3'b000, wanted_r});

  assign mem_waddr = AW'(body_m1);
  assign mem_raddr = AW'(k_r);

  // parameter byte store
  sbsp_param_mem #(
    .DEPTH (MAX_PARAMS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (rx_byte),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state of hunt, timeout and drain
  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    hunt_nxt      = hunt_r;
    awaited_nxt   = awaited_r;
    wanted_nxt    = wanted_r;
    frame_id_nxt  = frame_id_r;
    frame_len_nxt = frame_len_r;
    sum_nxt       = sum_r;
    body_nxt      = body_r;
    tick_nxt      = tick_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    outcome_nxt   = outcome_r;
    has_data_nxt  = has_data_r;
    pbyte_nxt     = pbyte_r;
    pidx_nxt      = pidx_r;
    last_nxt      = last_r;
    mem_we        = 1'b0;

    unique case (state_r)
      ST_RUN: begin
        if (in_acc) begin
          case (kind)
            sbsp_pkg::KIND_START: begin
              active_nxt    = 1'b1;
              hunt_nxt      = HP_FF1;
              awaited_nxt   = target_id;
              if ({3'b000, want_count} > CW'(MAX_PARAMS)) begin
                wanted_nxt = 5'(MAX_PARAMS);
              end else begin
                wanted_nxt = want_count;
              end
              frame_id_nxt  = 8'd0;
              frame_len_nxt = 8'd0;
              sum_nxt       = 8'd0;
              body_nxt      = 8'd0;
              tick_nxt      = 16'd0;
            end
            sbsp_pkg::KIND_BYTE: begin
              if (active_r) begin
                unique case (hunt_r)
                  HP_FF1: hunt_nxt = (rx_byte == sbsp_pkg::HDR_BYTE) ? HP_FF2 : HP_FF1;
                  HP_FF2: hunt_nxt = (rx_byte == sbsp_pkg::HDR_BYTE) ? HP_ID : HP_FF1;
                  HP_ID: begin
                    if (rx_byte != sbsp_pkg::HDR_BYTE) begin
                      frame_id_nxt = rx_byte;
                      sum_nxt      = rx_byte;
                      hunt_nxt     = HP_LEN;
                    end
                  end
                  HP_LEN: begin
                    frame_len_nxt = rx_byte;
                    sum_nxt       = sum_r + rx_byte;
                    body_nxt      = 8'd0;
                    hunt_nxt      = (rx_byte == 8'd0) ? HP_FF1 : HP_BODY;
                  end
                  default: begin
                    if ({1'b0, body_r} + 9'd1 < {1'b0, frame_len_r}) begin
                      // body byte: error byte first, then parameters
                      sum_nxt  = sum_r + rx_byte;
                      mem_we   = (body_r != 8'd0) &&
                                 ({1'b0, body_m1} < 9'(MAX_PARAMS));
                      body_nxt = body_r + 8'd1;
                    end else begin
                      // checksum byte
                      hunt_nxt = HP_FF1;
                      if (frame_ok) begin
                        active_nxt = 1'b0;
                        if (wanted_r == 5'd0) begin
                          out_valid_nxt = 1'b1;
                          outcome_nxt   = sbsp_pkg::OUTCOME_FRAME;
                          has_data_nxt  = 1'b0;
                          pbyte_nxt     = 8'd0;
                          pidx_nxt      = 4'd0;
                          last_nxt      = 1'b1;
                        end else begin
                          k_nxt     = 5'd0;
                          state_nxt = ST_READ;
                        end
                      end
                    end
                  end
                endcase
              end
            end
            sbsp_pkg::KIND_TICK: begin
              if (active_r) begin
                if (tick_inc >= {1'b0, timeout_r}) begin
                  active_nxt    = 1'b0;
                  hunt_nxt      = HP_FF1;
                  tick_nxt      = 16'd0;
                  out_valid_nxt = 1'b1;
                  outcome_nxt   = sbsp_pkg::OUTCOME_TIMEOUT;
                  has_data_nxt  = 1'b0;
                  pbyte_nxt     = 8'd0;
                  pidx_nxt      = 4'd0;
                  last_nxt      = 1'b1;
                end else begin
                  tick_nxt = tick_inc[15:0];
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        // store read in flight for entry k
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          outcome_nxt   = sbsp_pkg::OUTCOME_FRAME;
          has_data_nxt  = 1'b1;
          pbyte_nxt     = mem_rdata;
          pidx_nxt      = k_r[3:0];
          last_nxt      = (k_r + 5'd1 == wanted_r);
          if (k_r + 5'd1 == wanted_r) begin
            state_nxt = ST_RUN;
          end else begin
            k_nxt     = k_r + 5'd1;
            state_nxt = ST_READ;
          end
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      active_r    <= 1'b0;
      hunt_r      <= HP_FF1;
      awaited_r   <= 8'd0;
      wanted_r    <= 5'd0;
      frame_id_r  <= 8'd0;
      frame_len_r <= 8'd0;
      sum_r       <= 8'd0;
      body_r      <= 8'd0;
      tick_r      <= 16'd0;
      k_r         <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      hunt_r      <= hunt_nxt;
      awaited_r   <= awaited_nxt;
      wanted_r    <= wanted_nxt;
      frame_id_r  <= frame_id_nxt;
      frame_len_r <= frame_len_nxt;
      sum_r       <= sum_nxt;
      body_r      <= body_nxt;
      tick_r      <= tick_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // timeout register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= sbsp_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    outcome_r  <= outcome_nxt;
    has_data_r <= has_data_nxt;
    pbyte_r    <= pbyte_nxt;
    pidx_r     <= pidx_nxt;
    last_r     <= last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, pidx_r, pbyte_r};
  assign out_tuser  = {has_data_r, outcome_r};
  assign out_tlast  = last_r;

endmodule

// ----- design/sbsp_checker.sv -----
// ----------------------------------------------------------------------------
// sbsp_checker
// port level checks for the servo bus status parser, bound to the top level
// ----------------------------------------------------------------------------
module sbsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // a timeout is a single empty result
  a_timeout_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[0] == sbsp_pkg::OUTCOME_TIMEOUT) |->
      out_tlast && !out_tuser[1])
    else $error("timeout result malformed");

  // a result without data carries zero payload and ends the run
  a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> (out_tdata == 16'd0) && out_tlast)
    else $error("empty result malformed");

  // a start transaction gives no result
  a_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == sbsp_pkg::KIND_START) |=> !out_tvalid)
    else $error("result after start");

endmodule

bind servo_bus_status_parser sbsp_checker u_sbsp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
